// File: hdl/erol_pkg.sv
// Package with shared constants and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none

package erol_pkg;

  // Default number of descriptor slots in the ring.
  localparam int unsigned DEPTH_DEF = 16;

  // Widths of the transaction fields.
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned SLOT_W   = 4;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_FIND = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the input transaction and prepare a find walk
    logic do_add;    // store the latched entry and update the ring indexes
    logic find_run;  // advance the find walk by one step
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic find_done; // the find walk has its answer in this cycle
    logic out_free;  // the output register can take a result this cycle
  } sts_t;

endpackage : erol_pkg

`default_nettype wire

// File: hdl/erol_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module erol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : erol_ram

`default_nettype wire

// File: hdl/erol_ctrl.sv
// Controller state machine that sequences add and find transactions.
`timescale 1ns / 1ps
`default_nettype none

module erol_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          operation_i,
  input  wire erol_pkg::sts_t sts_i,
  output logic               in_stall_o,
  output erol_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_ADD    = 4'b0010,
    ST_FIND   = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (operation_i == erol_pkg::OP_FIND) ? ST_FIND : ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.do_add = 1'b1;
        state_d = ST_RESULT;
      end
      ST_FIND: begin
        cmd_o.find_run = 1'b1;
        if (sts_i.find_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // New transactions enter only while no earlier one is in flight.
  assign in_stall_o = (state_q != ST_IDLE);

endmodule : erol_ctrl

`default_nettype wire

// File: hdl/erol_dp.sv
// Datapath with ring indexes, slot memory, find walker and output register.
`timescale 1ns / 1ps
`default_nettype none

module erol_dp #(
  parameter int unsigned DEPTH = erol_pkg::DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire erol_pkg::cmd_t                  cmd_i,
  output erol_pkg::sts_t                       sts_o,
  input  wire logic [erol_pkg::HANDLE_W-1:0]   entry_handle_i,
  input  wire logic [erol_pkg::LENGTH_W-1:0]   entry_length_i,
  input  wire logic [erol_pkg::OFFSET_W-1:0]   byte_offset_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 found_o,
  output logic      [erol_pkg::SLOT_W-1:0]     slot_index_o,
  output logic      [erol_pkg::HANDLE_W-1:0]   handle_out_o,
  output logic      [erol_pkg::LENGTH_W-1:0]   byte_within_entry_o,
  output logic                                 overwrote_oldest_o,
  output logic                                 ring_full_o
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned HW  = erol_pkg::HANDLE_W;
  localparam int unsigned LW  = erol_pkg::LENGTH_W;
  localparam int unsigned OW  = erol_pkg::OFFSET_W;
  localparam int unsigned SW  = erol_pkg::SLOT_W;
  localparam int unsigned MW  = HW + LW;

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] idx);
    return (idx == IW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // Ring state.
  logic          full_q, full_d;
  logic [IW-1:0] wr_q, wr_d;
  logic [IW-1:0] rd_q, rd_d;

  // Latched add payload.
  logic [HW-1:0] handle_q;
  logic [LW-1:0] length_q;

  // Find walker.
  logic [OW-1:0] off_q, off_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] left_q, left_d;
  logic          chk_valid_q, chk_valid_d;
  logic [IW-1:0] chk_slot_q, chk_slot_d;

  // Finished result waiting for the output register.
  logic          res_found_q, res_found_d;
  logic [IW-1:0] res_slot_q, res_slot_d;
  logic [HW-1:0] res_handle_q, res_handle_d;
  logic [LW-1:0] res_within_q, res_within_d;
  logic          res_over_q, res_over_d;
  logic          res_full_q, res_full_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic          out_found_q;
  logic [SW-1:0] out_slot_q;
  logic [HW-1:0] out_handle_q;
  logic [LW-1:0] out_within_q;
  logic          out_over_q;
  logic          out_full_q;

  logic [MW-1:0] ram_rdata;
  logic [HW-1:0] rd_handle;
  logic [LW-1:0] rd_length;
  logic          issue;
  logic          hit;
  logic          walk_done;
  logic [CW-1:0] wr_ext, rd_ext, count;
  logic [IW-1:0] wr_next;
  logic [IW+SW-1:0] slot_ext;

  erol_ram #(
    .WIDTH (MW),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.do_add),
    .waddr_i (wr_q),
    .wdata_i ({handle_q, length_q}),
    .re_i    (issue),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_handle = ram_rdata[MW-1:LW];
  assign rd_length = ram_rdata[LW-1:0];

  assign wr_ext  = CW'(wr_q);
  assign rd_ext  = CW'(rd_q);
  assign count   = full_q ? CW'(DEPTH)
                 : ((wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (wr_ext + CW'(DEPTH) - rd_ext));
  assign wr_next = inc_idx(wr_q);

  assign hit       = chk_valid_q && (off_q < OW'(rd_length));
  assign issue     = cmd_i.find_run && (left_q != '0) && !hit;
  assign walk_done = hit || (!chk_valid_q && (left_q == '0));

  assign sts_o.find_done = walk_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    full_d       = full_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    off_d        = off_q;
    ptr_d        = ptr_q;
    left_d       = left_q;
    chk_valid_d  = chk_valid_q;
    chk_slot_d   = chk_slot_q;
    res_found_d  = res_found_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_within_d = res_within_q;
    res_over_d   = res_over_q;
    res_full_d   = res_full_q;

    if (cmd_i.capture) begin
      off_d       = byte_offset_i;
      ptr_d       = rd_q;
      left_d      = count;
      chk_valid_d = 1'b0;
    end

    if (cmd_i.do_add) begin
      wr_d         = wr_next;
      res_found_d  = 1'b0;
      res_slot_d   = wr_q;
      res_handle_d = '0;
      res_within_d = '0;
      res_over_d   = full_q;
      if (full_q) begin
        rd_d = inc_idx(rd_q);
      end else if (wr_next == rd_q) begin
        full_d = 1'b1;
      end
      res_full_d = full_q || (wr_next == rd_q);
    end

    if (cmd_i.find_run) begin
      if (chk_valid_q && !hit) begin
        off_d = off_q - OW'(rd_length);
      end
      chk_valid_d = issue;
      if (issue) begin
        chk_slot_d = ptr_q;
        ptr_d      = inc_idx(ptr_q);
        left_d     = left_q - 1'b1;
      end
      if (walk_done) begin
        res_found_d  = hit;
        res_slot_d   = hit ? chk_slot_q : '0;
        res_handle_d = hit ? rd_handle : '0;
        res_within_d = hit ? off_q[LW-1:0] : '0;
        res_over_d   = 1'b0;
        res_full_d   = full_q;
      end
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  assign slot_ext    = {{SW{1'b0}}, res_slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q      <= 1'b0;
      wr_q        <= '0;
      rd_q        <= '0;
      left_q      <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      full_q      <= full_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      left_q      <= left_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      handle_q <= entry_handle_i;
      length_q <= entry_length_i;
    end
    off_q        <= off_d;
    ptr_q        <= ptr_d;
    chk_slot_q   <= chk_slot_d;
    res_found_q  <= res_found_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_within_q <= res_within_d;
    res_over_q   <= res_over_d;
    res_full_q   <= res_full_d;
    if (cmd_i.out_load) begin
      out_found_q  <= res_found_q;
      out_slot_q   <= slot_ext[SW-1:0];
      out_handle_q <= res_handle_q;
      out_within_q <= res_within_q;
      out_over_q   <= res_over_q;
      out_full_q   <= res_full_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign found_o             = out_found_q;
  assign slot_index_o        = out_slot_q;
  assign handle_out_o        = out_handle_q;
  assign byte_within_entry_o = out_within_q;
  assign overwrote_oldest_o  = out_over_q;
  assign ring_full_o         = out_full_q;

endmodule : erol_dp

`default_nettype wire

// File: hdl/entry_ring_offset_lookup.sv
// One transaction is handled at a time. An add stores its slot and then reports; a find walks
// the stored slots from the read index, one stored length per cycle, until a hit or until
// every stored slot is checked. A finished result waits until the output register is free.
// Reset: rst_ni is asynchronous and active low; it empties the ring and clears valid.
// Slot contents are not cleared; a slot is only read after it has been written.
`timescale 1ns / 1ps
`default_nettype none

module entry_ring_offset_lookup #(
  parameter int unsigned DEPTH = erol_pkg::DEPTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Input channel.
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            operation_i,
  input  wire logic [erol_pkg::HANDLE_W-1:0]   entry_handle_i,
  input  wire logic [erol_pkg::LENGTH_W-1:0]   entry_length_i,
  input  wire logic [erol_pkg::OFFSET_W-1:0]   byte_offset_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 found_o,
  output logic      [erol_pkg::SLOT_W-1:0]     slot_index_o,
  output logic      [erol_pkg::HANDLE_W-1:0]   handle_out_o,
  output logic      [erol_pkg::LENGTH_W-1:0]   byte_within_entry_o,
  output logic                                 overwrote_oldest_o,
  output logic                                 ring_full_o
);

  // The controller decides what happens in each cycle; the datapath holds the
  // ring indexes, the slot RAM, the find walker and the output register.
  erol_pkg::cmd_t cmd;
  erol_pkg::sts_t sts;

  erol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  // An add writes the slot at the write index and advances it. When the ring
  // is already full the oldest entry is dropped by advancing the read index.
  // A find walks the valid slots from the read index, subtracting each stored
  // length from the offset until the offset lies inside one entry. The RAM
  // read is registered, so the walker issues one address per cycle and checks
  // the length of the previous one; no read is issued past a hit.
  erol_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .entry_handle_i      (entry_handle_i),
    .entry_length_i      (entry_length_i),
    .byte_offset_i       (byte_offset_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .found_o             (found_o),
    .slot_index_o        (slot_index_o),
    .handle_out_o        (handle_out_o),
    .byte_within_entry_o (byte_within_entry_o),
    .overwrote_oldest_o  (overwrote_oldest_o),
    .ring_full_o         (ring_full_o)
  );

endmodule : entry_ring_offset_lookup

`default_nettype wire

// File: hdl/erol_checker.sv
// Port-level checker for the ring lookup block and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module erol_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          found_o,
  input wire logic [erol_pkg::HANDLE_W-1:0] handle_out_o,
  input wire logic [erol_pkg::LENGTH_W-1:0] byte_within_entry_o,
  input wire logic                          overwrote_oldest_o,
  input wire logic                          ring_full_o
);

  // A taken transaction must raise the input stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction is in flight");

  // Dropping the oldest entry only happens on a full ring, and only for an add.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overwrote_oldest_o) |-> (ring_full_o && !found_o))
    else $error("overwrite reported without a full ring or on a find hit");

  // Results without a hit carry neither a handle nor a byte position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> ((handle_out_o == '0) && (byte_within_entry_o == '0)))
    else $error("handle or byte position set without a hit");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(found_o) && $stable(handle_out_o) && $stable(ring_full_o)))
    else $error("stalled result changed");

endmodule : erol_checker

bind entry_ring_offset_lookup erol_checker u_erol_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .found_o             (found_o),
  .handle_out_o        (handle_out_o),
  .byte_within_entry_o (byte_within_entry_o),
  .overwrote_oldest_o  (overwrote_oldest_o),
  .ring_full_o         (ring_full_o)
);

`default_nettype wire
